// ===== hw/rtl/ffb_pkg.sv =====
// shared types, constants and codes for the command filter fifo
package ffb_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int COMMAND_BYTES = 7;

   localparam int KIND_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int BYTES_W  = 64;
   localparam int FRONT_W  = 56;
   localparam int FILL_W   = 5;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 3;
   localparam int CMD_W    = COMMAND_BYTES * BYTE_W;

   localparam logic [BYTE_W-1:0] TARGET_ID     = 8'h05;
   localparam logic [BYTE_W-1:0] MODE_PREFIX   = 8'hf8;
   localparam logic [BYTE_W-1:0] MODE_NORMAL   = 8'h01;
   localparam logic [BYTE_W-1:0] MODE_AUTO     = 8'h09;
   localparam logic [BYTE_W-1:0] MODE_RANGE    = 8'h0a;
   localparam logic [BYTE_W-1:0] MODE_NATIVE   = 8'h10;
   localparam logic [BYTE_W-1:0] MODE_EXTENDED = 8'h11;

   typedef enum logic [KIND_W-1:0] {
      KIND_ENQUEUE = 2'd0,
      KIND_POP     = 2'd1,
      KIND_CLEAR   = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_QUEUED   = 3'd0,
      ST_INVALID  = 3'd1,
      ST_BLOCKED  = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_DONE     = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  id_code;
      logic               data_present;
      logic [BYTE_W-1:0]  report_length;
      logic [BYTES_W-1:0] report_bytes;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               front_valid;
      logic [FRONT_W-1:0] front_command;
      logic [FILL_W-1:0]  fill_level;
      logic [FILL_W-1:0]  high_water_mark;
      logic [COUNT_W-1:0] received_total;
      logic [COUNT_W-1:0] invalid_total;
      logic [COUNT_W-1:0] blocked_total;
      logic [COUNT_W-1:0] overflow_total;
      logic [COUNT_W-1:0] sent_total;
   } rsp_type;

   typedef struct packed {
      status_type         status;
      logic [FRONT_W-1:0] command;
   } class_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/ffb_command_filter_fifo.sv =====
// top level: command filter, shifting command queue and statistics counters
//
// One transaction per clock: start is taken whenever busy is low, and busy
// never rises, so a new transaction may follow in every cycle. Each
// transaction gives exactly one result, shown on rsp_payload with rsp_strobe
// high for a single cycle, set at the accepting edge; the receiver cannot
// stall and must take it then. The queue is a row of slots with the oldest
// command in slot zero: a pop moves every slot one place toward the front, a
// push loads the slot at the current fill level. Clear only resets the fill
// level; the counters and the high water mark are kept. Counters wrap.
module ffb_command_filter_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ffb_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output ffb_pkg::rsp_type rsp_payload
);
   import ffb_pkg::*;

   class_type          verdict;
   cell_ctrl_type      cell_ctrl [QUEUE_DEPTH];
   logic [FRONT_W-1:0] cell_data [QUEUE_DEPTH];
   logic [FRONT_W-1:0] cell_next [QUEUE_DEPTH];

   logic               accept;
   logic               push;
   logic               pop_shift;

   logic               rsp_strobe_ff, rsp_strobe_in;
   status_type         status_ff, status_in;
   logic [FILL_W-1:0]  occupancy_ff, occupancy_in;
   logic [FILL_W-1:0]  peak_ff, peak_in;
   logic [COUNT_W-1:0] received_ff, received_in;
   logic [COUNT_W-1:0] invalid_ff, invalid_in;
   logic [COUNT_W-1:0] blocked_ff, blocked_in;
   logic [COUNT_W-1:0] overflow_ff, overflow_in;
   logic [COUNT_W-1:0] sent_ff, sent_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   ffb_classify u_classify (
      .req     (req_payload),
      .verdict (verdict)
   );

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign cell_next[gi] = '0;
         end else begin : g_link
            assign cell_next[gi] = cell_data[gi+1];
         end
         assign cell_ctrl[gi].shift = pop_shift;
         assign cell_ctrl[gi].load  = push && occupancy_ff == FILL_W'(gi);

         ffb_cell u_cell (
            .clock         (clock),
            .ctrl          (cell_ctrl[gi]),
            .load_data     (verdict.command),
            .neighbor_data (cell_next[gi]),
            .data          (cell_data[gi])
         );
      end
   endgenerate

   always_comb begin
      rsp_strobe_in = accept;
      status_in     = status_ff;
      occupancy_in  = occupancy_ff;
      peak_in       = peak_ff;
      received_in   = received_ff;
      invalid_in    = invalid_ff;
      blocked_in    = blocked_ff;
      overflow_in   = overflow_ff;
      sent_in       = sent_ff;
      push          = 1'b0;
      pop_shift     = 1'b0;

      if (accept) begin
         unique case (req_payload.kind)
            KIND_ENQUEUE: begin
               unique case (verdict.status)
                  ST_INVALID: begin
                     invalid_in = invalid_ff + 1'b1;
                     status_in  = ST_INVALID;
                  end
                  ST_BLOCKED: begin
                     blocked_in = blocked_ff + 1'b1;
                     status_in  = ST_BLOCKED;
                  end
                  default: begin
                     received_in = received_ff + 1'b1;
                     if (occupancy_ff >= FILL_W'(QUEUE_DEPTH)) begin
                        overflow_in = overflow_ff + 1'b1;
                        status_in   = ST_OVERFLOW;
                     end else begin
                        push         = 1'b1;
                        occupancy_in = occupancy_ff + 1'b1;
                        status_in    = ST_QUEUED;
                        if (occupancy_in > peak_ff) begin
                           peak_in = occupancy_in;
                        end
                     end
                  end
               endcase
            end
            KIND_POP: begin
               if (occupancy_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  pop_shift    = 1'b1;
                  occupancy_in = occupancy_ff - 1'b1;
                  sent_in      = sent_ff + 1'b1;
                  status_in    = ST_DONE;
               end
            end
            KIND_CLEAR: begin
               occupancy_in = '0;
               status_in    = ST_DONE;
            end
            default: begin
               status_in = ST_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         occupancy_ff  <= '0;
         peak_ff       <= '0;
         received_ff   <= '0;
         invalid_ff    <= '0;
         blocked_ff    <= '0;
         overflow_ff   <= '0;
         sent_ff       <= '0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
         occupancy_ff  <= occupancy_in;
         peak_ff       <= peak_in;
         received_ff   <= received_in;
         invalid_ff    <= invalid_in;
         blocked_ff    <= blocked_in;
         overflow_ff   <= overflow_in;
         sent_ff       <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   assign rsp_strobe = rsp_strobe_ff;

   always_comb begin
      rsp_payload.status          = status_ff;
      rsp_payload.front_valid     = occupancy_ff != '0;
      rsp_payload.front_command   = (occupancy_ff != '0) ? cell_data[0] : '0;
      rsp_payload.fill_level      = occupancy_ff;
      rsp_payload.high_water_mark = peak_ff;
      rsp_payload.received_total  = received_ff;
      rsp_payload.invalid_total   = invalid_ff;
      rsp_payload.blocked_total   = blocked_ff;
      rsp_payload.overflow_total  = overflow_ff;
      rsp_payload.sent_total      = sent_ff;
   end

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("fill level beyond queue depth");

   a_peak_covers_fill: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= occupancy_ff)
      else $error("high water mark below fill level");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted transaction gave no result");

   a_pop_counts: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.kind == KIND_POP && occupancy_ff != '0
      |=> sent_ff == $past(sent_ff) + 1'b1 && occupancy_ff == $past(occupancy_ff) - 1'b1)
      else $error("pop did not advance counters");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.status == ST_OVERFLOW |-> occupancy_ff == FILL_W'(QUEUE_DEPTH))
      else $error("overflow reported with room in queue");
`endif

endmodule

// ===== hw/rtl/ffb_classify.sv =====
// report normalization, validity check and mode-change blocking
module ffb_classify (
   input  ffb_pkg::req_type   req,
   output ffb_pkg::class_type verdict
);
   import ffb_pkg::*;

   logic               strip_lead;
   logic [BYTE_W-1:0]  id_n;
   logic [BYTE_W-1:0]  len_n;
   logic [BYTES_W-1:0] bytes_n;
   logic [BYTE_W-1:0]  b0;
   logic [BYTE_W-1:0]  b1;
   logic               malformed;
   logic               mode_change;

   always_comb begin
      strip_lead = 1'b0;
      if (req.id_code == '0 && req.report_length != '0 &&
          req.report_bytes[BYTE_W-1:0] == TARGET_ID) begin
         strip_lead = 1'b1;
      end else if (req.id_code != TARGET_ID &&
                   req.report_length > BYTE_W'(COMMAND_BYTES)) begin
         strip_lead = 1'b1;
      end
      id_n    = strip_lead ? TARGET_ID : req.id_code;
      len_n   = strip_lead ? req.report_length - 1'b1 : req.report_length;
      bytes_n = strip_lead ? (req.report_bytes >> BYTE_W) : req.report_bytes;
      b0      = bytes_n[BYTE_W-1:0];
      b1      = bytes_n[2*BYTE_W-1:BYTE_W];

      malformed   = !req.data_present || id_n != TARGET_ID ||
                    len_n < BYTE_W'(COMMAND_BYTES);
      mode_change = b0 == MODE_PREFIX &&
                    (b1 inside {MODE_NORMAL, MODE_AUTO, MODE_RANGE,
                                MODE_NATIVE, MODE_EXTENDED});

      verdict.command = FRONT_W'(bytes_n[CMD_W-1:0]);
      if (malformed) begin
         verdict.status = ST_INVALID;
      end else if (mode_change) begin
         verdict.status = ST_BLOCKED;
      end else begin
         verdict.status = ST_QUEUED;
      end
   end

endmodule

// ===== hw/rtl/ffb_cell.sv =====
// one queue slot of the shifting command chain
module ffb_cell (
   input  logic                         clock,
   input  ffb_pkg::cell_ctrl_type       ctrl,
   input  logic [ffb_pkg::FRONT_W-1:0]  load_data,
   input  logic [ffb_pkg::FRONT_W-1:0]  neighbor_data,
   output logic [ffb_pkg::FRONT_W-1:0]  data
);
   import ffb_pkg::*;

   logic [FRONT_W-1:0] data_ff;
   logic [FRONT_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = load_data;
      end else if (ctrl.shift) begin
         data_in = neighbor_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== tb/sv/tb_ffb_command_filter_fifo.sv =====
`timescale 1ns / 100ps
// testbench for the command filter fifo: directed and random transactions
module tb_ffb_command_filter_fifo;
   import ffb_pkg::*;

   class fifo_tracker;
      rsp_type            pending_results[$];
      logic [CMD_W-1:0]   held_commands[$];
      logic [FILL_W-1:0]  peak_fill;
      logic [COUNT_W-1:0] received_count;
      logic [COUNT_W-1:0] invalid_count;
      logic [COUNT_W-1:0] blocked_count;
      logic [COUNT_W-1:0] overflow_count;
      logic [COUNT_W-1:0] sent_count;
      int                 failures;

      function new();
         peak_fill      = '0;
         received_count = '0;
         invalid_count  = '0;
         blocked_count  = '0;
         overflow_count = '0;
         sent_count     = '0;
         failures       = 0;
      endfunction

      function status_type filter_report(req_type r);
         logic [BYTE_W-1:0]  id;
         logic [BYTE_W-1:0]  len;
         logic [BYTES_W-1:0] bytes;
         logic [BYTE_W-1:0]  b0;
         logic [BYTE_W-1:0]  b1;
         id    = r.id_code;
         len   = r.report_length;
         bytes = r.report_bytes;
         if (!r.data_present) begin
            invalid_count++;
            return ST_INVALID;
         end
         // drop a lead byte for a target-id prefix or long foreign report
         if (id == 8'h00 && len != 8'h00 && bytes[7:0] == TARGET_ID) begin
            bytes = bytes >> BYTE_W;
            len   = len - 8'd1;
            id    = TARGET_ID;
         end else if (id != TARGET_ID && len > COMMAND_BYTES) begin
            bytes = bytes >> BYTE_W;
            len   = len - 8'd1;
            id    = TARGET_ID;
         end
         if (id != TARGET_ID || len < COMMAND_BYTES) begin
            invalid_count++;
            return ST_INVALID;
         end
         b0 = bytes[7:0];
         b1 = bytes[15:8];
         if (b0 == MODE_PREFIX &&
             b1 inside {MODE_NORMAL, MODE_AUTO, MODE_RANGE, MODE_NATIVE, MODE_EXTENDED}) begin
            blocked_count++;
            return ST_BLOCKED;
         end
         received_count++;
         if (held_commands.size() >= QUEUE_DEPTH) begin
            overflow_count++;
            return ST_OVERFLOW;
         end
         held_commands.push_back(bytes[CMD_W-1:0]);
         if (FILL_W'(held_commands.size()) > peak_fill)
            peak_fill = FILL_W'(held_commands.size());
         return ST_QUEUED;
      endfunction

      function void note_transaction(req_type r);
         rsp_type e;
         e = '0;
         case (r.kind)
            KIND_ENQUEUE: begin
               e.status = filter_report(r);
            end
            KIND_POP: begin
               if (held_commands.size() == 0) begin
                  e.status = ST_EMPTY;
               end else begin
                  void'(held_commands.pop_front());
                  sent_count++;
                  e.status = ST_DONE;
               end
            end
            KIND_CLEAR: begin
               held_commands.delete();
               e.status = ST_DONE;
            end
            default: begin
               e.status = ST_EMPTY;
            end
         endcase
         e.front_valid     = held_commands.size() != 0;
         e.front_command   = e.front_valid ? FRONT_W'(held_commands[0]) : '0;
         e.fill_level      = FILL_W'(held_commands.size());
         e.high_water_mark = peak_fill;
         e.received_total  = received_count;
         e.invalid_total   = invalid_count;
         e.blocked_total   = blocked_count;
         e.overflow_total  = overflow_count;
         e.sent_total      = sent_count;
         pending_results.push_back(e);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h actual %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_type r);
         rsp_type e;
         if (pending_results.size() == 0) begin
            $error("result with no transaction outstanding");
            failures++;
            return;
         end
         e = pending_results.pop_front();
         compare_field("status", 64'(e.status), 64'(r.status));
         compare_field("front_valid", 64'(e.front_valid), 64'(r.front_valid));
         compare_field("front_command", 64'(e.front_command), 64'(r.front_command));
         compare_field("fill_level", 64'(e.fill_level), 64'(r.fill_level));
         compare_field("high_water_mark", 64'(e.high_water_mark),
                       64'(r.high_water_mark));
         compare_field("received_total", 64'(e.received_total), 64'(r.received_total));
         compare_field("invalid_total", 64'(e.invalid_total), 64'(r.invalid_total));
         compare_field("blocked_total", 64'(e.blocked_total), 64'(r.blocked_total));
         compare_field("overflow_total", 64'(e.overflow_total), 64'(r.overflow_total));
         compare_field("sent_total", 64'(e.sent_total), 64'(r.sent_total));
      endfunction
   endclass

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   fifo_tracker tracker;
   int          cycle_count = 0;

   ffb_command_filter_fifo u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.check_result(rsp_payload);
      if (!reset && start && !busy)
         tracker.note_transaction(req_payload);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_ffb_command_filter_fifo failed");
         $finish;
      end
   end

   function automatic req_type report(logic [BYTE_W-1:0] id, logic present,
                                      logic [BYTE_W-1:0] len, logic [BYTES_W-1:0] bytes);
      req_type r;
      r.kind          = KIND_ENQUEUE;
      r.id_code       = id;
      r.data_present  = present;
      r.report_length = len;
      r.report_bytes  = bytes;
      return r;
   endfunction

   function automatic req_type control_item(logic [KIND_W-1:0] kind);
      req_type r;
      r = report(8'($urandom), 1'($urandom), 8'($urandom), {$urandom, $urandom});
      r.kind = kind;
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_mode();
      case ($urandom_range(0, 4))
         0:       return MODE_NORMAL;
         1:       return MODE_AUTO;
         2:       return MODE_RANGE;
         3:       return MODE_NATIVE;
         default: return MODE_EXTENDED;
      endcase
   endfunction

   function automatic req_type random_report();
      logic [BYTES_W-1:0] bytes;
      logic [BYTE_W-1:0]  len;
      bytes = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 6))
                                              : 8'($urandom_range(7, 255));
            return report(TARGET_ID, 1'b1, len, bytes);
         end
         3: begin
            bytes[7:0] = TARGET_ID;
            return report(8'h00, 1'b1, 8'($urandom_range(0, 255)), bytes);
         end
         4: return report(8'($urandom), 1'b1, 8'($urandom), bytes);
         5: begin
            if ($urandom_range(0, 1) == 0) begin
               bytes[15:0] = {pick_mode(), MODE_PREFIX};
               return report(TARGET_ID, 1'b1, 8'($urandom_range(7, 255)), bytes);
            end
            bytes[23:0] = {pick_mode(), MODE_PREFIX, TARGET_ID};
            return report(8'h00, 1'b1, 8'($urandom_range(8, 255)), bytes);
         end
         6: begin
            bytes[7:0] = MODE_PREFIX;
            return report(TARGET_ID, 1'b1, 8'($urandom_range(7, 255)), bytes);
         end
         7: return report(8'($urandom), 1'b0, 8'($urandom), bytes);
         8: return report(8'($urandom), 1'($urandom), 8'($urandom), bytes);
         default: return report(TARGET_ID, 1'b1, 8'($urandom_range(7, 8)), bytes);
      endcase
   endfunction

   task automatic send_transaction(req_type r, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic run_directed();
      send_transaction(control_item(KIND_POP), 0);
      send_transaction(control_item(KIND_UNUSED), 0);
      send_transaction(control_item(KIND_CLEAR), 1);
      send_transaction(report(TARGET_ID, 1'b0, 8'hff, '1), 0);
      send_transaction(report(TARGET_ID, 1'b1, 8'd7, '1), 2);
      send_transaction(report(TARGET_ID, 1'b1, 8'd6, {$urandom, $urandom}), 0);
      send_transaction(report(8'h00, 1'b1, 8'd8, 64'h1122_3344_5566_7705), 0);
      send_transaction(report(8'h00, 1'b1, 8'd7, 64'h1122_3344_5566_7705), 3);
      send_transaction(report(8'h00, 1'b1, 8'd0, 64'h1122_3344_5566_7705), 0);
      send_transaction(report(8'hff, 1'b1, 8'd8, 64'h8899_aabb_ccdd_eeff), 0);
      send_transaction(report(8'h03, 1'b1, 8'd7, {$urandom, $urandom}), 13);
      send_transaction(report(8'h03, 1'b1, 8'hff, '1), 0);
      send_transaction(report(TARGET_ID, 1'b1, 8'd7, {48'h0, MODE_NORMAL, MODE_PREFIX}), 0);
      send_transaction(report(TARGET_ID, 1'b1, 8'd9, {48'h0, MODE_AUTO, MODE_PREFIX}), 0);
      send_transaction(report(TARGET_ID, 1'b1, 8'd7, {48'h0, MODE_RANGE, MODE_PREFIX}), 1);
      send_transaction(report(TARGET_ID, 1'b1, 8'd7, {48'h0, MODE_NATIVE, MODE_PREFIX}), 0);
      send_transaction(report(TARGET_ID, 1'b1, 8'd7,
                              {48'hffff_ffff_ffff, MODE_EXTENDED, MODE_PREFIX}), 0);
      send_transaction(report(8'h00, 1'b1, 8'd8,
                              {40'h0, MODE_AUTO, MODE_PREFIX, TARGET_ID}), 0);
      send_transaction(report(TARGET_ID, 1'b1, 8'd7, {48'h0, 8'h02, MODE_PREFIX}), 4);
      send_transaction(report(TARGET_ID, 1'b1, 8'd7, 64'h0), 0);
      send_transaction(control_item(KIND_POP), 0);
      send_transaction(control_item(KIND_UNUSED), 0);
      send_transaction(control_item(KIND_CLEAR), 0);
      send_transaction(control_item(KIND_POP), 0);
   endtask

   task automatic run_random();
      mix_type mix;
      bit      calm;
      int      pick;
      int      gap;
      req_type r;
      for (int phase = 0; phase < 14; phase++) begin
         mix  = mix_type'($urandom_range(0, 2));
         calm = $urandom_range(0, 2) == 0;
         for (int i = 0; i < 50; i++) begin
            pick = $urandom_range(0, 99);
            case (mix)
               MIX_FILL:  pick = (pick < 85) ? 0 : (pick < 95) ? 1 : (pick < 98) ? 2 : 3;
               MIX_DRAIN: pick = (pick < 30) ? 0 : (pick < 95) ? 1 : (pick < 98) ? 2 : 3;
               default:   pick = (pick < 55) ? 0 : (pick < 93) ? 1 : (pick < 97) ? 2 : 3;
            endcase
            case (pick)
               0:       r = random_report();
               1:       r = control_item(KIND_POP);
               2:       r = control_item(KIND_CLEAR);
               default: r = control_item(KIND_UNUSED);
            endcase
            gap = calm ? 0 : $urandom_range(0, 13);
            send_transaction(r, gap);
         end
      end
   endtask

   initial begin
      tracker     = new;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      start <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (tracker.pending_results.size() != 0) begin
         $error("transactions left without a result");
         tracker.failures++;
      end
      if (tracker.failures == 0)
         $display("tb_ffb_command_filter_fifo passed");
      else
         $display("tb_ffb_command_filter_fifo failed");
      $finish;
   end

endmodule
